// File: src/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LEN_START    = 6'd56;

    // block command from the front part to the compression engine
    typedef struct packed {
        logic [511:0] block;
        logic         emit;
    } blk_cmd_t;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// File: src/sha_front.sv
// Front part: packs bytes into blocks, builds padding blocks, issues block commands.
`default_nettype none
module sha_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  sha_pkg::in_item_t    in_item,
    output logic                 cmd_valid,
    input  wire logic            cmd_ready,
    output sha_pkg::blk_cmd_t    cmd
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_TAKE = 3'b001,
        ST_PAD  = 3'b010,
        ST_LEN  = 3'b100
    } st_t;

    st_t          st_reg, st_next;
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  count_reg, count_next;
    logic         cvalid_reg, cvalid_next;
    blk_cmd_t     cmd_reg, cmd_next;
    logic [511:0] padded;
    logic [63:0]  bits;

    assign in_ready  = (st_reg == ST_TAKE) && !cvalid_reg;
    assign cmd_valid = cvalid_reg;
    assign cmd       = cmd_reg;
    assign bits      = {count_reg, 3'b000};

    // buffer with byte at fill position set to 0x80 and later bytes zeroed
    always_comb
    begin
        padded = buf_reg;
        for (int i = 0; i < 64; i++)
        begin
            if (i == int'(fill_reg))
                padded[511 - 8*i -: 8] = PAD_BYTE;
            else if (i > int'(fill_reg))
                padded[511 - 8*i -: 8] = 8'h00;
        end
    end

    always_comb
    begin
        st_next     = st_reg;
        buf_next    = buf_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        cvalid_next = cvalid_reg && !cmd_ready;
        cmd_next    = cmd_reg;
        case (st_reg)
            ST_TAKE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_item.mode == MODE_BYTE)
                    begin
                        buf_next[511 - 8*fill_reg -: 8] = in_item.data_byte;
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        if (fill_reg == 6'd63)
                        begin
                            cmd_next.block = buf_next;
                            cmd_next.emit  = 1'b0;
                            cvalid_next    = 1'b1;
                        end
                    end
                    else
                        st_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (!cvalid_reg)
                begin
                    if (fill_reg < LEN_START)
                    begin
                        cmd_next.block = {padded[511:64], bits};
                        cmd_next.emit  = 1'b1;
                        cvalid_next    = 1'b1;
                        st_next        = ST_TAKE;
                        fill_next      = '0;
                        count_next     = '0;
                    end
                    else
                    begin
                        cmd_next.block = padded;
                        cmd_next.emit  = 1'b0;
                        cvalid_next    = 1'b1;
                        st_next        = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                if (!cvalid_reg)
                begin
                    cmd_next.block = {448'd0, bits};
                    cmd_next.emit  = 1'b1;
                    cvalid_next    = 1'b1;
                    st_next        = ST_TAKE;
                    fill_next      = '0;
                    count_next     = '0;
                end
            end
            default: st_next = ST_TAKE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_TAKE;
            fill_reg   <= '0;
            count_reg  <= '0;
            cvalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            cvalid_reg <= cvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        cmd_reg <= cmd_next;
    end
endmodule
`default_nettype wire

// File: src/sha_queue.sv
// Two-entry queue of block commands between front and engine.
`default_nettype none
module sha_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  sha_pkg::blk_cmd_t  wr_cmd,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output sha_pkg::blk_cmd_t  rd_cmd
);
    import sha_pkg::*;

    blk_cmd_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_cmd   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_cmd;
    end
endmodule
`default_nettype wire

// File: src/sha_engine.sv
// Back part: 64-round compression, one round per cycle, and digest word output.
`default_nettype none
module sha_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  sha_pkg::blk_cmd_t  cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sha_pkg::out_item_t out_item
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FOLD  = 4'b0100,
        ST_EMIT  = 4'b1000
    } st_t;

    st_t          st_reg;
    logic [5:0]   t_reg;
    logic [2:0]   idx_reg;
    logic         emit_reg;
    logic         ovalid_reg;
    out_item_t    oitem_reg;
    logic [255:0] chain_reg;
    logic [511:0] w_reg;
    logic [31:0]  v_reg [8];

    logic [31:0] w0, w1, w9, w14, s0, s1, wnew, e, a, t1, t2;

    assign w0  = w_reg[511 -: 32];
    assign w1  = w_reg[479 -: 32];
    assign w9  = w_reg[223 -: 32];
    assign w14 = w_reg[63 -: 32];
    assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign wnew = w0 + s0 + w9 + s1;
    assign a   = v_reg[0];
    assign e   = v_reg[4];
    assign t1  = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
               + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(t_reg) + w0;
    assign t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
               + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign cmd_ready = (st_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            t_reg      <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
            chain_reg  <= INIT_HASH;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                    if (cmd_valid)
                    begin
                        st_reg <= ST_ROUND;
                        t_reg  <= '0;
                    end
                ST_ROUND:
                begin
                    t_reg <= t_reg + 6'd1;
                    if (t_reg == 6'd63)
                        st_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[255 - 32*i -: 32] <= chain_reg[255 - 32*i -: 32] + v_reg[i];
                    idx_reg <= '0;
                    st_reg  <= emit_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg <= 1'b1;
                        idx_reg    <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            st_reg    <= ST_IDLE;
                            chain_reg <= INIT_HASH;
                        end
                    end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && cmd_valid)
        begin
            w_reg    <= cmd.block;
            emit_reg <= cmd.emit;
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain_reg[255 - 32*i -: 32];
        end
        else if (st_reg == ST_ROUND)
        begin
            // window shifts left; new schedule word enters at the tail
            w_reg    <= {w_reg[479:0], wnew};
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (st_reg == ST_EMIT && (!ovalid_reg || out_ready))
        begin
            oitem_reg.digest_word <= chain_reg[255 - 32*idx_reg -: 32];
            oitem_reg.word_index  <= idx_reg;
            oitem_reg.last_word   <= (idx_reg == 3'd7);
        end
    end
endmodule
`default_nettype wire

// File: src/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte-stream hasher.
//   channel | dir | payload              | handshake
//   in      | in  | in_item_t (mode,byte) | in_valid / in_ready
//   out     | out | out_item_t (word,idx,last) | out_valid / out_ready
// Bytes are taken one per cycle while the front holds no pending block.
// Each block runs load, 64 rounds and fold in the engine; a full block
// stalls input until the 2-entry queue takes it, and input backs up while
// that queue is full. Finish holds input while the front issues the padded
// last block (plus a length block on spill); 8 digest items follow it.
// Reset clears all control state and restores the initial hash value.
`default_nettype none
module sha256_byte_stream_hasher_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  sha_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sha_pkg::out_item_t out_item
);
    import sha_pkg::*;

    blk_cmd_t f_cmd, q_cmd;
    logic     f_valid, f_ready, q_valid, q_ready;

    sha_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_item,
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

    sha_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd));

    sha_engine u_engine (
        .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_valid, .out_ready, .out_item);
endmodule
`default_nettype wire

// File: src/sha_checker.sv
// Port-level checker for the SHA-256 byte-stream hasher, bound to the top level.
`default_nettype none
module sha_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire sha_pkg::out_item_t out_item
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.last_word == (out_item.word_index == 3'd7)))
        else $error("last_word disagrees with word_index");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last_word |=> !out_valid ||
        out_item.word_index == $past(out_item.word_index) + 3'd1)
        else $error("digest words out of order");
endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (
    .clk, .rst_n, .out_valid, .out_ready, .out_item);
`default_nettype wire

// File: tb/testbench.sv
// Testbench for the SHA-256 byte-stream hasher: random and directed messages against a predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    class digest_board;
        logic [31:0] chain [8];
        logic [7:0]  blk [64];
        logic [5:0]  fill;
        logic [60:0] nbytes;
        out_item_t   pending [$];
        int          errors;
        int          words_seen;
        int          messages;

        function new();
            errors = 0;
            words_seen = 0;
            messages = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                chain[i] = INIT_HASH[255 - 32 * i -: 32];
            fill = '0;
            nbytes = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void fold_block();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, s0, s1;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(w[i - 15], 7) ^ ror(w[i - 15], 18) ^ (w[i - 15] >> 3);
                s1 = ror(w[i - 2], 17) ^ ror(w[i - 2], 19) ^ (w[i - 2] >> 10);
                w[i] = w[i - 16] + s0 + w[i - 7] + s1;
            end
            for (int i = 0; i < 8; i++)
                v[i] = chain[i];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                    + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                    + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += v[i];
        endfunction

        function void note_input(in_item_t it);
            logic [63:0] bits;
            int f;
            out_item_t o;
            if (it.mode == MODE_BYTE)
            begin
                blk[fill] = it.data_byte;
                fill++;
                nbytes++;
                if (fill == 0)
                    fold_block();
                return;
            end
            bits = {nbytes, 3'b000};
            blk[fill] = PAD_BYTE;
            f = fill + 1;
            if (f > 56)
            begin
                for (int i = f; i < 64; i++)
                    blk[i] = '0;
                fold_block();
                f = 0;
            end
            for (int i = f; i < 56; i++)
                blk[i] = '0;
            for (int i = 0; i < 8; i++)
                blk[56 + i] = bits[63 - 8 * i -: 8];
            fold_block();
            for (int i = 0; i < 8; i++)
            begin
                o.digest_word = chain[i];
                o.word_index = i[2:0];
                o.last_word = (i == 7);
                pending.push_back(o);
            end
            messages++;
            restart();
        endfunction

        function void check_word(out_item_t got);
            out_item_t want;
            words_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest word %h idx %0d last %0b",
                    $time, got.digest_word, got.word_index, got.last_word);
                return;
            end
            want = pending.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                errors++;
                $display("%0t: digest_word expected %h actual %h",
                    $time, want.digest_word, got.digest_word);
            end
            if (got.word_index !== want.word_index)
            begin
                errors++;
                $display("%0t: word_index expected %0d actual %0d",
                    $time, want.word_index, got.word_index);
            end
            if (got.last_word !== want.last_word)
            begin
                errors++;
                $display("%0t: last_word expected %0b actual %0b",
                    $time, want.last_word, got.last_word);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    digest_board board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    longint cycles;

    sha256_byte_stream_hasher_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
        .out_item(out_item)
    );

    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    // receiver: random stall, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                board.check_word(out_item);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // valid stays up between back-to-back items; it drops only while idling
    task automatic send_item(logic m, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{mode: m, data_byte: b};
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(in_item);
    endtask

    task automatic send_message(int len, int pattern);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (pattern)
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom_range(255));
            endcase
            send_item(MODE_BYTE, b);
        end
        send_item(MODE_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    int lens [4] = '{0, 1, 2, 3};

    initial
    begin
        board = new();
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty messages, short messages of all-zero / all-one / random bytes
        send_item(MODE_FINISH, 8'hff);
        send_message(3, 0);
        send_message(3, 1);
        send_item(MODE_FINISH, 8'h00);
        send_message(5, 2);
        wait_drained();
        // padding boundaries: 56 bytes spills into a second block, 64 fills one exactly
        send_message(56, 2);
        send_message(64, 0);
        wait_drained();
        // long receiver hold-off while short messages keep coming
        hold_off = 400;
        for (int m = 0; m < 5; m++)
            send_message(2, 2);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 57 : 24) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 57 : 24) : 0;
            for (int m = 0; m < 2; m++)
                send_message(lens[$urandom_range(3)], 2);
            wait_drained();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        $display("Covered %0d messages, %0d digest words: empty, padding boundaries,",
            board.messages, board.words_seen);
        $display("multi-block input, back-pressure and random idle/stall phases.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
src/sha_pkg.sv
src/sha_front.sv
src/sha_queue.sv
src/sha_engine.sv
src/sha256_byte_stream_hasher_unit.sv
src/sha_checker.sv
tb/testbench.sv
